// ===== rtl/radix_text_to_integer_parser_defines.svh =====
// assertion helpers for the parser top file
`ifndef RADIX_TEXT_TO_INTEGER_PARSER_DEFINES_SVH
`define RADIX_TEXT_TO_INTEGER_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RTIP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtip assertion failed");

// next-cycle implication, checked out of reset
`define RTIP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtip assertion failed");

`endif

// ===== rtl/rtip_pkg.sv =====
package rtip_pkg;

    // field widths
    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 6;
    localparam int BOUND_W     = 64;
    localparam int VALUE_W_DEF = 64;

    // radix constants
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;

    // register reset values
    localparam logic [RADIX_W-1:0] BASE_RESET  = RADIX_DEC;
    localparam logic [BOUND_W-1:0] UPPER_RESET = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [BOUND_W-1:0] LOWER_RESET = 64'h8000_0000_0000_0000;

    // character codes
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UC_X  = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_X  = 8'h78;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] LETTER_OFS = 8'd10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_BASE  = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_LOWER = 2'd2
    } t_cfg_index;

    // parse phase
    typedef enum logic [1:0] {
        PH_WAIT        = 2'd0,
        PH_AFTER_SIGN  = 2'd1,
        PH_PREFIX_ZERO = 2'd2,
        PH_DIGITS      = 2'd3
    } t_phase;

    // parser control state
    typedef struct packed {
        t_phase             phase;
        logic               neg;
        logic [RADIX_W-1:0] radix;
        logic               failed;
        logic               zero_seen;
        logic               digit_seen;
        logic               run_ended;
    } t_parse_ctl;

    localparam t_parse_ctl CTL_RESET = '{
        phase:      PH_WAIT,
        neg:        1'b0,
        radix:      RADIX_DEC,
        failed:     1'b0,
        zero_seen:  1'b0,
        digit_seen: 1'b0,
        run_ended:  1'b0
    };

    // channel payloads
    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic [BOUND_W-1:0] value;
        logic               ok;
    } t_out_item;

endpackage

// ===== rtl/radix_text_to_integer_parser.sv =====
// Parses signed integer text one character per cycle: leading whitespace is
// skipped, an optional sign is taken, then digits in the configured radix
// (2..36, or auto-detected 0x/0 prefix when base_select is 0) are summed
// against the configured bound. One item is taken every clock while the
// result register is free or being drained; a result appears on the cycle
// after the item flagged last_char, and any trailing text after the first
// whitespace-free run is ignored. Each character costs one pass through a
// VALUE_WIDTH x 6 multiply-add and bound compare, which sets the clock.
// Configuration writes are always taken and should only be issued between
// strings.
`include "radix_text_to_integer_parser_defines.svh"

module radix_text_to_integer_parser #(
    parameter int VALUE_WIDTH = rtip_pkg::VALUE_W_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rtip_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rtip_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [rtip_pkg::BOUND_W-1:0]  i_cfg_data
);

    logic [rtip_pkg::RADIX_W-1:0] r_base_select;
    logic [rtip_pkg::BOUND_W-1:0] r_upper_bound;
    logic [rtip_pkg::BOUND_W-1:0] r_lower_bound;
    rtip_pkg::t_parse_ctl         r_ctl;
    logic [VALUE_WIDTH-1:0]       r_acc;
    logic                         r_out_valid;
    rtip_pkg::t_out_item          r_out_item;
    rtip_pkg::t_parse_ctl         n_ctl;
    logic [VALUE_WIDTH-1:0]       n_acc;
    rtip_pkg::t_out_item          n_out_item;
    logic                         in_acc;
    logic                         cfg_acc;

    // handshakes
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_select <= rtip_pkg::BASE_RESET;
            r_upper_bound <= rtip_pkg::UPPER_RESET;
            r_lower_bound <= rtip_pkg::LOWER_RESET;
        end else if (cfg_acc) begin
            unique case (rtip_pkg::t_cfg_index'(i_cfg_index))
                rtip_pkg::CFG_BASE:  r_base_select <= i_cfg_data[rtip_pkg::RADIX_W-1:0];
                rtip_pkg::CFG_UPPER: r_upper_bound <= i_cfg_data;
                rtip_pkg::CFG_LOWER: r_lower_bound <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-character next state
    rtip_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_item        (i_in_item),
        .i_ctl         (r_ctl),
        .i_acc         (r_acc),
        .i_base_select (r_base_select),
        .i_upper_bound (r_upper_bound),
        .i_lower_bound (r_lower_bound),
        .o_ctl         (n_ctl),
        .o_acc         (n_acc),
        .o_result      (n_out_item)
    );

    // parse state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= rtip_pkg::CTL_RESET;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_ctl <= n_ctl;
                r_acc <= n_acc;
            end
            if (in_acc && i_in_item.last_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.last_char) begin
            r_out_item <= n_out_item;
        end
    end

    // checks
    `RTIP_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, r_out_valid && !r_out_item.ok, r_out_item.value == '0)
    `RTIP_ASSERT_NEXT(a_drain, i_clk, i_rst_n, r_out_valid && i_out_ready && !(in_acc && i_in_item.last_char), !r_out_valid)
    `RTIP_ASSERT_NEXT(a_restart, i_clk, i_rst_n, in_acc && i_in_item.last_char, r_ctl.phase == rtip_pkg::PH_WAIT && r_acc == '0 && r_out_valid)

endmodule

// ===== rtl/rtip_step.sv =====
module rtip_step #(
    parameter int VALUE_WIDTH = rtip_pkg::VALUE_W_DEF
) (
    input  rtip_pkg::t_in_item                 i_item,
    input  rtip_pkg::t_parse_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0]             i_acc,
    input  logic [rtip_pkg::RADIX_W-1:0]       i_base_select,
    input  logic [rtip_pkg::BOUND_W-1:0]       i_upper_bound,
    input  logic [rtip_pkg::BOUND_W-1:0]       i_lower_bound,
    output rtip_pkg::t_parse_ctl               o_ctl,
    output logic [VALUE_WIDTH-1:0]             o_acc,
    output rtip_pkg::t_out_item                o_result
);

    localparam int PW = VALUE_WIDTH + rtip_pkg::RADIX_W + 1;
    localparam logic [rtip_pkg::BOUND_W-1:0] CAP =
        (VALUE_WIDTH >= rtip_pkg::BOUND_W) ? '1 :
        ((rtip_pkg::BOUND_W'(1) << VALUE_WIDTH) - rtip_pkg::BOUND_W'(1));

    logic [rtip_pkg::CHAR_W-1:0]  c;
    logic                         blank;
    logic                         is_sign;
    logic                         dv;
    logic [rtip_pkg::CHAR_W-1:0]  dwide;
    logic [rtip_pkg::RADIX_W-1:0] d;
    logic [rtip_pkg::RADIX_W-1:0] rsel;
    logic                         take;
    logic [rtip_pkg::RADIX_W-1:0] r_eff;
    logic [rtip_pkg::BOUND_W-1:0] lbmag;
    logic [rtip_pkg::BOUND_W:0]   bsum;
    logic [rtip_pkg::BOUND_W-1:0] b64;
    logic [VALUE_WIDTH-1:0]       bound;
    logic [PW-1:0]                prod;
    rtip_pkg::t_parse_ctl         s;
    rtip_pkg::t_parse_ctl         s_dig;
    logic [VALUE_WIDTH-1:0]       acc;
    logic                         ok;
    logic [rtip_pkg::BOUND_W-1:0] mag;

    // character classes and digit value
    always_comb begin
        c       = i_item.char_code;
        blank   = (c == rtip_pkg::CH_SPACE) ||
                  (c >= rtip_pkg::CH_TAB && c <= rtip_pkg::CH_CR);
        is_sign = (c == rtip_pkg::CH_PLUS) || (c == rtip_pkg::CH_MINUS);
        dv      = 1'b1;
        dwide   = '0;
        if (c >= rtip_pkg::CH_ZERO && c <= rtip_pkg::CH_NINE) begin
            dwide = c - rtip_pkg::CH_ZERO;
        end else if (c >= rtip_pkg::CH_LC_A && c <= rtip_pkg::CH_LC_Z) begin
            dwide = c - rtip_pkg::CH_LC_A + rtip_pkg::LETTER_OFS;
        end else if (c >= rtip_pkg::CH_UC_A && c <= rtip_pkg::CH_UC_Z) begin
            dwide = c - rtip_pkg::CH_UC_A + rtip_pkg::LETTER_OFS;
        end else begin
            dv = 1'b0;
        end
        d = dwide[rtip_pkg::RADIX_W-1:0];
    end

    // radix picked from the base register at the first non-space
    always_comb begin
        if (i_base_select == rtip_pkg::RADIX_AUTO) begin
            rsel = rtip_pkg::RADIX_AUTO;
        end else if (i_base_select < rtip_pkg::RADIX_MIN ||
                     i_base_select > rtip_pkg::RADIX_MAX) begin
            rsel = rtip_pkg::RADIX_DEC;
        end else begin
            rsel = i_base_select;
        end
    end

    // phase transitions, decides whether this char is a digit to take
    always_comb begin
        s     = i_ctl;
        take  = 1'b0;
        r_eff = i_ctl.radix;
        if (i_ctl.run_ended) begin
            s = i_ctl;
        end else if (i_ctl.phase == rtip_pkg::PH_WAIT) begin
            if (!blank) begin
                s.radix = rsel;
                if (is_sign) begin
                    s.neg   = (c == rtip_pkg::CH_MINUS);
                    s.phase = rtip_pkg::PH_AFTER_SIGN;
                end else if (rsel == rtip_pkg::RADIX_AUTO && c == rtip_pkg::CH_ZERO) begin
                    s.zero_seen = 1'b1;
                    s.phase     = rtip_pkg::PH_PREFIX_ZERO;
                end else begin
                    if (rsel == rtip_pkg::RADIX_AUTO) begin
                        s.radix = rtip_pkg::RADIX_DEC;
                    end
                    s.phase = rtip_pkg::PH_DIGITS;
                    take    = 1'b1;
                end
            end
        end else if (blank) begin
            s.run_ended = 1'b1;
        end else begin
            unique case (i_ctl.phase)
                rtip_pkg::PH_AFTER_SIGN: begin
                    if (i_ctl.radix == rtip_pkg::RADIX_AUTO && c == rtip_pkg::CH_ZERO) begin
                        s.zero_seen = 1'b1;
                        s.phase     = rtip_pkg::PH_PREFIX_ZERO;
                    end else begin
                        if (i_ctl.radix == rtip_pkg::RADIX_AUTO) begin
                            s.radix = rtip_pkg::RADIX_DEC;
                        end
                        s.phase = rtip_pkg::PH_DIGITS;
                        take    = 1'b1;
                    end
                end
                rtip_pkg::PH_PREFIX_ZERO: begin
                    s.phase = rtip_pkg::PH_DIGITS;
                    if (c == rtip_pkg::CH_LC_X || c == rtip_pkg::CH_UC_X) begin
                        s.radix     = rtip_pkg::RADIX_HEX;
                        s.zero_seen = 1'b0;
                    end else begin
                        s.radix = rtip_pkg::RADIX_OCT;
                        take    = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
        end
        r_eff = s.radix;
    end

    // bound for this digit: negative decimal uses the lower bound magnitude
    always_comb begin
        lbmag = i_lower_bound[rtip_pkg::BOUND_W-1] ? (rtip_pkg::BOUND_W'(0) - i_lower_bound) : '0;
        bsum  = {1'b0, i_upper_bound} + {1'b0, lbmag};
        if (r_eff == rtip_pkg::RADIX_DEC) begin
            b64 = (s.neg && lbmag != '0) ? lbmag : i_upper_bound;
        end else begin
            b64 = bsum[rtip_pkg::BOUND_W] ? '1 : bsum[rtip_pkg::BOUND_W-1:0];
        end
        bound = (b64 > CAP) ? CAP[VALUE_WIDTH-1:0] : b64[VALUE_WIDTH-1:0];
    end

    // multiply-add and overflow check
    assign prod = PW'(i_acc) * PW'(r_eff) + PW'(d);

    always_comb begin
        s_dig = s;
        acc   = i_acc;
        if (take) begin
            if (r_eff < rtip_pkg::RADIX_MIN || !dv || d >= r_eff) begin
                s_dig.failed = 1'b1;
            end else begin
                if (d == '0) begin
                    s_dig.zero_seen = 1'b1;
                end else begin
                    s_dig.digit_seen = 1'b1;
                end
                if (!i_ctl.failed) begin
                    if (prod > PW'(bound)) begin
                        s_dig.failed = 1'b1;
                    end else begin
                        acc = prod[VALUE_WIDTH-1:0];
                    end
                end
            end
        end
    end

    // result on the last char, then back to the idle parse state
    always_comb begin
        ok  = !s_dig.failed && (s_dig.zero_seen || s_dig.digit_seen);
        mag = rtip_pkg::BOUND_W'(acc);
        o_result.ok    = ok;
        o_result.value = !ok ? '0 : (s_dig.neg ? (rtip_pkg::BOUND_W'(0) - mag) : mag);
        if (i_item.last_char) begin
            o_ctl = rtip_pkg::CTL_RESET;
            o_acc = '0;
        end else begin
            o_ctl = s_dig;
            o_acc = acc;
        end
    end

endmodule

// ===== bench/radix_text_to_integer_parser_tb.sv =====
module radix_text_to_integer_parser_tb;
    import rtip_pkg::*;

    localparam int VALUE_WIDTH = VALUE_W_DEF;
    localparam int IDLE_LIMIT = 5000;
    localparam int PHASE_CHARS = 130;
    localparam int unsigned NO_DIGIT = 99;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TOP = 8'hFF;

    typedef logic [CHAR_W-1:0] text_t[$];

    // parser state mirror and queue of numbers still owed by the block
    class int_parse_scoreboard;
        logic [RADIX_W-1:0] base_sel;
        logic [BOUND_W-1:0] upper;
        logic [BOUND_W-1:0] lower;
        t_phase             phase;
        bit                 neg;
        int unsigned        radix;
        logic [BOUND_W-1:0] acc;
        bit                 failed;
        bit                 zero_seen;
        bit                 digit_seen;
        bit                 run_ended;
        t_out_item          parsed_numbers[$];
        int                 errors;

        function new();
            base_sel = BASE_RESET;
            upper = UPPER_RESET;
            lower = LOWER_RESET;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            phase = PH_WAIT;
            neg = 1'b0;
            radix = RADIX_DEC;
            acc = '0;
            failed = 1'b0;
            zero_seen = 1'b0;
            digit_seen = 1'b0;
            run_ended = 1'b0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [BOUND_W-1:0] data);
            case (idx)
                CFG_BASE: base_sel = data[RADIX_W-1:0];
                CFG_UPPER: upper = data;
                CFG_LOWER: lower = data;
                default: ;
            endcase
        endfunction

        // largest magnitude allowed for this radix and sign
        function logic [BOUND_W-1:0] bound_for(int unsigned rdx, bit negative);
            logic [BOUND_W-1:0] lbmag;
            logic [BOUND_W-1:0] b;
            logic [BOUND_W-1:0] cap;
            logic [BOUND_W:0]   total;
            cap = {BOUND_W{1'b1}} >> (BOUND_W - VALUE_WIDTH);
            lbmag = lower[BOUND_W-1] ? -lower : '0;
            if (rdx == RADIX_DEC) begin
                b = (negative && lbmag != 0) ? lbmag : upper;
            end else begin
                total = {1'b0, upper} + {1'b0, lbmag};
                b = total[BOUND_W] ? {BOUND_W{1'b1}} : total[BOUND_W-1:0];
            end
            return (b < cap) ? b : cap;
        endfunction

        function bit is_blank(logic [CHAR_W-1:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function int unsigned digit_value(logic [CHAR_W-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
            if (c >= CH_LC_A && c <= CH_LC_Z) return c - CH_LC_A + LETTER_OFS;
            if (c >= CH_UC_A && c <= CH_UC_Z) return c - CH_UC_A + LETTER_OFS;
            return NO_DIGIT;
        endfunction

        function void take_digit(logic [CHAR_W-1:0] c);
            int unsigned d;
            logic [BOUND_W-1:0] b;
            d = digit_value(c);
            if (radix < RADIX_MIN || d >= radix) begin
                failed = 1'b1;
                return;
            end
            if (d == 0) zero_seen = 1'b1;
            else digit_seen = 1'b1;
            if (failed) return;
            b = bound_for(radix, neg);
            if (b < d || acc > (b - d) / radix) begin
                failed = 1'b1;
                return;
            end
            acc = acc * radix + d;
        endfunction

        // first body char after any sign, where auto prefix is decided
        function void take_first_body(logic [CHAR_W-1:0] c);
            if (radix == RADIX_AUTO) begin
                if (c == CH_ZERO) begin
                    zero_seen = 1'b1;
                    phase = PH_PREFIX_ZERO;
                    return;
                end
                radix = RADIX_DEC;
            end
            phase = PH_DIGITS;
            take_digit(c);
        endfunction

        function void advance(logic [CHAR_W-1:0] c);
            if (run_ended) return;
            if (phase == PH_WAIT) begin
                if (is_blank(c)) return;
                if (base_sel == RADIX_AUTO) radix = RADIX_AUTO;
                else if (base_sel < RADIX_MIN || base_sel > RADIX_MAX) radix = RADIX_DEC;
                else radix = base_sel;
                if (c == CH_MINUS || c == CH_PLUS) begin
                    neg = (c == CH_MINUS);
                    phase = PH_AFTER_SIGN;
                    return;
                end
                take_first_body(c);
                return;
            end
            if (is_blank(c)) begin
                run_ended = 1'b1;
                return;
            end
            case (phase)
                PH_AFTER_SIGN: take_first_body(c);
                PH_PREFIX_ZERO: begin
                    phase = PH_DIGITS;
                    if (c == CH_LC_X || c == CH_UC_X) begin
                        radix = RADIX_HEX;
                        zero_seen = 1'b0;
                    end else begin
                        radix = RADIX_OCT;
                        take_digit(c);
                    end
                end
                default: take_digit(c);
            endcase
        endfunction

        function void note_char(t_in_item it);
            t_out_item num;
            advance(it.char_code);
            if (it.last_char) begin
                num.ok = !failed && (zero_seen || digit_seen);
                num.value = num.ok ? (neg ? -acc : acc) : '0;
                parsed_numbers.push_back(num);
                clear_string();
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (parsed_numbers.size() == 0) begin
                $display("%0t: unexpected result value=%h ok=%b", $time, got.value, got.ok);
                errors++;
                return;
            end
            want = parsed_numbers.pop_front();
            if (got.value !== want.value) begin
                $display("%0t: value mismatch expected=%h actual=%h",
                         $time, want.value, got.value);
                errors++;
            end
            if (got.ok !== want.ok) begin
                $display("%0t: ok mismatch expected=%b actual=%b", $time, want.ok, got.ok);
                errors++;
            end
        endfunction

        function int pending();
            return parsed_numbers.size();
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    t_in_item           i_in_item = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic [1:0]         i_cfg_index = '0;
    logic [BOUND_W-1:0] i_cfg_data = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic               o_cfg_ready;

    int_parse_scoreboard number_check;
    bit                  steady = 1'b0;
    int unsigned         chars_sent = 0;

    radix_text_to_integer_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: check accepted items, then pick the next ready level
    initial begin
        int unsigned stall_left;
        int unsigned r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) number_check.check_result(o_out_item);
            if (steady) begin
                i_out_ready <= 1'b1;
            end else if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    i_out_ready <= 1'b1;
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    stall_left = $urandom_range(15, 40);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) idle = 0;
            else idle++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned in_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 9);
        return $urandom_range(20, 40);
    endfunction

    task automatic put_char(logic [CHAR_W-1:0] c, logic last);
        t_in_item    it;
        int unsigned gap;
        it.char_code = c;
        it.last_char = last;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        number_check.note_char(it);
        chars_sent++;
        gap = in_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic put_text(text_t s);
        for (int i = 0; i < s.size(); i++) put_char(s[i], i == s.size() - 1);
    endtask

    task automatic put_word(string w);
        for (int i = 0; i < w.len(); i++) put_char(w[i], i == w.len() - 1);
    endtask

    // hold the sender until every owed number has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (number_check.pending() > 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [BOUND_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        number_check.write_reg(idx, data);
    endtask

    task automatic configure(logic [RADIX_W-1:0] base, logic [BOUND_W-1:0] up,
                             logic [BOUND_W-1:0] lo);
        settle();
        cfg_write(CFG_BASE, base);
        cfg_write(CFG_UPPER, up);
        cfg_write(CFG_LOWER, lo);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
        logic [CHAR_W-1:0] letter_base;
        letter_base = $urandom_range(0, 1) ? CH_UC_A : CH_LC_A;
        if (d < LETTER_OFS) return CH_ZERO + CHAR_W'(d);
        return letter_base + CHAR_W'(d) - LETTER_OFS;
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        int unsigned r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? CH_SPACE : CH_TAB + CHAR_W'(r);
    endfunction

    function automatic logic [BOUND_W-1:0] rand_bound();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    function automatic int unsigned fixed_radix();
        int unsigned b;
        b = number_check.base_sel;
        if (b == RADIX_AUTO) return RADIX_DEC;
        if (b < RADIX_MIN || b > RADIX_MAX) return RADIX_DEC;
        return b;
    endfunction

    // number text with random content, often right at the bound
    function automatic text_t well_formed();
        text_t              s;
        int unsigned        rdx;
        int unsigned        sel;
        int unsigned        n;
        bit                 negative;
        logic [BOUND_W-1:0] mag;
        logic [BOUND_W-1:0] lim;
        text_t              digits;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) s.push_back(blank_char());
        sel = $urandom_range(0, 3);
        negative = (sel == 1);
        if (sel == 1) s.push_back(CH_MINUS);
        else if (sel == 2) s.push_back(CH_PLUS);
        rdx = fixed_radix();
        if (number_check.base_sel == RADIX_AUTO) begin
            sel = $urandom_range(0, 2);
            if (sel == 0) begin
                s.push_back(CH_ZERO);
                s.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
                rdx = RADIX_HEX;
            end else if (sel == 1) begin
                s.push_back(CH_ZERO);
                rdx = RADIX_OCT;
            end
        end
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) s.push_back(CH_ZERO);
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            mag = $urandom_range(0, 9999);
        end else if (sel < 7) begin
            mag = rand_bound();
        end else begin
            lim = number_check.bound_for(rdx, negative);
            case ($urandom_range(0, 2))
                0: mag = lim - 1;
                1: mag = lim;
                default: mag = lim + 1;
            endcase
        end
        n = 0;
        while (mag != 0 || n == 0) begin
            digits.push_front(digit_char(32'(mag % rdx)));
            mag = mag / rdx;
            n++;
        end
        foreach (digits[i]) s.push_back(digits[i]);
        sel = $urandom_range(0, 5);
        if (sel == 0) begin
            s.push_back(blank_char());
            repeat ($urandom_range(1, 3)) s.push_back(CHAR_W'($urandom_range(0, 255)));
        end else if (sel == 1) begin
            s.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        return s;
    endfunction

    // noise and cut-off number text
    function automatic text_t broken();
        text_t       s;
        int unsigned rdx;
        rdx = fixed_radix();
        case ($urandom_range(0, 5))
            0: repeat ($urandom_range(1, 5)) s.push_back(CHAR_W'($urandom_range(0, 255)));
            1: begin
                s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                if ($urandom_range(0, 1)) s.push_back(blank_char());
            end
            2: begin
                s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                s.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
                s.push_back(digit_char($urandom_range(1, rdx - 1)));
            end
            3: begin
                s.push_back(digit_char($urandom_range(1, rdx - 1)));
                s.push_back(rdx < RADIX_MAX ? digit_char(rdx) : CH_LC_Z + 8'd1);
            end
            4: repeat ($urandom_range(1, 3)) s.push_back(blank_char());
            default: begin
                s.push_back(CH_ZERO);
                s.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
            end
        endcase
        return s;
    endfunction

    task automatic run_phase(logic [RADIX_W-1:0] base, logic [BOUND_W-1:0] up,
                             logic [BOUND_W-1:0] lo, bit calm);
        int unsigned phase_end;
        int unsigned halfway;
        bit          held;
        configure(base, up, lo);
        steady = calm;
        phase_end = chars_sent + PHASE_CHARS;
        halfway = chars_sent + PHASE_CHARS / 2;
        held = 1'b0;
        while (chars_sent < phase_end) begin
            if ($urandom_range(0, 99) < 80) put_text(well_formed());
            else put_text(broken());
            // drain everything once mid-phase
            if (!held && chars_sent >= halfway) begin
                settle();
                held = 1'b1;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        number_check = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings with the reset settings
        put_word(" ");
        put_word("+");
        put_word("0");
        put_word("-7");
        put_char(CH_TOP, 1'b1);
        put_char(CH_NUL, 1'b1);
        put_word(" 5 x");
        put_word("1+");
        put_word("00");

        // directed prefix strings with a small unsigned bound
        configure(RADIX_AUTO, 64'd100, '0);
        put_word("0x");
        put_word("0X1F");
        put_word("017");
        put_word("-9");
        put_word("999");

        // unused-index write, meant to change nothing (nothing checks it)
        settle();
        cfg_write(CFG_SPARE, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;

        run_phase(RADIX_DEC, UPPER_RESET, LOWER_RESET, 1'b0);
        run_phase(RADIX_AUTO, {BOUND_W{1'b1}}, '0, 1'b0);
        run_phase(RADIX_MIN, 64'hFF, 64'hFFFF_FFFF_FFFF_FF80, 1'b0);
        run_phase(RADIX_MAX, 64'h7FFF_FFFF, 64'hFFFF_FFFF_8000_0000, 1'b1);
        run_phase(RADIX_HEX, {BOUND_W{1'b1}}, LOWER_RESET, 1'b0);
        run_phase(6'd1, 64'd1000, 64'd5, 1'b0);
        run_phase(RADIX_OCT, '0, '0, 1'b0);
        run_phase(6'd63, rand_bound(), {$urandom, $urandom}, 1'b1);
        run_phase(RADIX_AUTO, rand_bound(), -rand_bound(), 1'b0);
        run_phase(RADIX_W'($urandom_range(0, 63)), rand_bound(), {$urandom, $urandom}, 1'b0);

        settle();
        repeat (10) @(posedge i_clk);
        if (number_check.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
